FILE: sv/utt_pkg.sv
// Shared types, constants and helpers of the UTF-8 to UTF-16/UTF-32 transcoder.
// No dependencies; every other file of the block refers to this package.
package utt_pkg;

  localparam int unsigned CodeW   = 21;
  localparam int unsigned MaxUnits = 3;

  // Configuration register indexes
  localparam logic CFG_OUTPUT_UTF32  = 1'b0;
  localparam logic CFG_NUL_TERMINATE = 1'b1;

  localparam logic [CodeW-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
  localparam logic [CodeW-1:0] SUPP_BASE        = 21'h010000;
  localparam logic [CodeW-1:0] CODE_LIMIT       = 21'h110000;
  localparam logic [CodeW-1:0] TWO_BYTE_MIN     = 21'h000080;
  localparam logic [CodeW-1:0] THREE_BYTE_MIN   = 21'h000800;
  localparam logic [15:0]      HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0]      LOW_SURR_BASE    = 16'hDC00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_unit;
    logic             unit_valid;
    logic             text_done;
    logic             had_errors;
  } unit_t;

  // Up to three results caused by one item, count gives how many are live
  typedef struct packed {
    unit_t [MaxUnits-1:0] units;
    logic  [1:0]          count;
  } bundle_t;

  // Bits 15..10 of a unit read 110110
  function automatic logic is_high_surrogate(logic [CodeW-1:0] u);
    is_high_surrogate = (u[15:10] == HIGH_SURR_BASE[15:10]);
  endfunction

  function automatic unit_t plain_unit(logic [CodeW-1:0] u, logic err);
    plain_unit = '{code_unit: u, unit_valid: 1'b1, text_done: 1'b0, had_errors: err};
  endfunction

endpackage

FILE: sv/utt_if.sv
// Handshake channels of the transcoder: byte input and code-unit output.
// Depends on utt_pkg for the code-unit width.
interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, has_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_text, output ready);
endinterface

interface utt_out_if;
  logic                      valid;
  logic                      ready;
  logic [utt_pkg::CodeW-1:0] code_unit;
  logic                      unit_valid;
  logic                      last_of_item;
  logic                      text_done;
  logic                      had_errors;

  modport source (output valid, code_unit, unit_valid, last_of_item, text_done, had_errors,
                  input ready);
  modport sink   (input valid, code_unit, unit_valid, last_of_item, text_done, had_errors,
                  output ready);
endinterface

FILE: sv/utt_decode.sv
// Decoder state and per-item decode: turns one registered item into up to three results.
// Depends on utt_pkg.
module utt_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  utt_pkg::item_t  item,
  input  logic            output_utf32,
  input  logic            nul_terminate,
  output utt_pkg::bundle_t bundle
);

  logic [1:0]                bytes_remaining, bytes_remaining_next;
  logic [1:0]                sequence_length, sequence_length_next;
  logic [utt_pkg::CodeW-1:0] code_accumulator, code_accumulator_next;
  logic                      skipping, skipping_next;
  logic                      prev_high, prev_high_next;
  logic                      error_seen, error_seen_next;

  utt_pkg::unit_t [utt_pkg::MaxUnits-1:0] units;
  logic [1:0]                cnt;
  logic                      cont;
  logic                      lead;
  logic [1:0]                len;
  logic [utt_pkg::CodeW-1:0] u;
  logic [utt_pkg::CodeW-1:0] v;

  always_comb begin
    bytes_remaining_next  = bytes_remaining;
    sequence_length_next  = sequence_length;
    code_accumulator_next = code_accumulator;
    skipping_next         = skipping;
    prev_high_next        = prev_high;
    error_seen_next       = error_seen;
    units = '0;
    cnt   = 2'd0;
    lead  = 1'b0;
    len   = 2'd0;
    u     = '0;
    v     = '0;
    cont  = (item.data_byte[7:6] == 2'b10);

    if (item.has_byte) begin
      if (bytes_remaining_next != 2'd0) begin
        if (!cont) begin
          // sequence cut short: replace, then treat this byte as a lead
          bytes_remaining_next  = 2'd0;
          sequence_length_next  = 2'd0;
          code_accumulator_next = '0;
          error_seen_next       = 1'b1;
          if (cnt != 2'd3) begin
            units[cnt] = utt_pkg::plain_unit(utt_pkg::REPLACEMENT_CHAR, error_seen_next);
            cnt = cnt + 2'd1;
          end
          prev_high_next = 1'b0;
          skipping_next  = 1'b0;
          lead           = 1'b1;
        end else begin
          code_accumulator_next = {code_accumulator_next[14:0], item.data_byte[5:0]};
          bytes_remaining_next  = bytes_remaining_next - 2'd1;
          if (bytes_remaining_next == 2'd0) begin
            u   = code_accumulator_next;
            len = sequence_length_next;
            sequence_length_next  = 2'd0;
            code_accumulator_next = '0;
            case (len)
              2'd1: begin
                if (u < utt_pkg::TWO_BYTE_MIN) begin
                  error_seen_next = 1'b1;
                  skipping_next   = 1'b1;
                  u               = utt_pkg::REPLACEMENT_CHAR;
                end
                if (cnt != 2'd3) begin
                  units[cnt] = utt_pkg::plain_unit(u, error_seen_next);
                  cnt = cnt + 2'd1;
                end
                prev_high_next = utt_pkg::is_high_surrogate(u);
              end
              2'd2: begin
                if (u < utt_pkg::THREE_BYTE_MIN) begin
                  error_seen_next = 1'b1;
                  skipping_next   = 1'b1;
                  u               = utt_pkg::REPLACEMENT_CHAR;
                end else if (u[15:11] == utt_pkg::HIGH_SURR_BASE[15:11]) begin
                  error_seen_next = 1'b1;
                  if (u[15:10] == utt_pkg::LOW_SURR_BASE[15:10] && prev_high_next) begin
                    // low surrogate would pair with the unit before it
                    skipping_next = 1'b1;
                    u             = utt_pkg::REPLACEMENT_CHAR;
                  end
                end
                if (cnt != 2'd3) begin
                  units[cnt] = utt_pkg::plain_unit(u, error_seen_next);
                  cnt = cnt + 2'd1;
                end
                prev_high_next = utt_pkg::is_high_surrogate(u);
              end
              default: begin
                if (u < utt_pkg::SUPP_BASE || u >= utt_pkg::CODE_LIMIT) begin
                  error_seen_next = 1'b1;
                  skipping_next   = 1'b1;
                  if (cnt != 2'd3) begin
                    units[cnt] = utt_pkg::plain_unit(utt_pkg::REPLACEMENT_CHAR,
                                                     error_seen_next);
                    cnt = cnt + 2'd1;
                  end
                  prev_high_next = 1'b0;
                end else if (!output_utf32) begin
                  // split into a surrogate pair
                  v = u - utt_pkg::SUPP_BASE;
                  if (cnt != 2'd3) begin
                    units[cnt] = utt_pkg::plain_unit(
                        {5'd0, utt_pkg::HIGH_SURR_BASE[15:10], v[19:10]}, error_seen_next);
                    cnt = cnt + 2'd1;
                  end
                  if (cnt != 2'd3) begin
                    units[cnt] = utt_pkg::plain_unit(
                        {5'd0, utt_pkg::LOW_SURR_BASE[15:10], v[9:0]}, error_seen_next);
                    cnt = cnt + 2'd1;
                  end
                  prev_high_next = 1'b0;
                end else begin
                  if (cnt != 2'd3) begin
                    units[cnt] = utt_pkg::plain_unit(u, error_seen_next);
                    cnt = cnt + 2'd1;
                  end
                  prev_high_next = utt_pkg::is_high_surrogate(u);
                end
              end
            endcase
          end
        end
      end else if (!(skipping_next && cont)) begin
        skipping_next = 1'b0;
        lead          = 1'b1;
      end

      if (lead) begin
        if (item.data_byte < 8'h80) begin
          if (cnt != 2'd3) begin
            units[cnt] = utt_pkg::plain_unit({13'd0, item.data_byte}, error_seen_next);
            cnt = cnt + 2'd1;
          end
          prev_high_next = 1'b0;
        end else if (item.data_byte < 8'hC0 || item.data_byte >= 8'hF8) begin
          error_seen_next = 1'b1;
          if (cnt != 2'd3) begin
            units[cnt] = utt_pkg::plain_unit(utt_pkg::REPLACEMENT_CHAR, error_seen_next);
            cnt = cnt + 2'd1;
          end
          prev_high_next = 1'b0;
          skipping_next  = 1'b1;
        end else if (item.data_byte < 8'hE0) begin
          code_accumulator_next = {16'd0, item.data_byte[4:0]};
          bytes_remaining_next  = 2'd1;
          sequence_length_next  = 2'd1;
        end else if (item.data_byte < 8'hF0) begin
          code_accumulator_next = {17'd0, item.data_byte[3:0]};
          bytes_remaining_next  = 2'd2;
          sequence_length_next  = 2'd2;
        end else begin
          code_accumulator_next = {18'd0, item.data_byte[2:0]};
          bytes_remaining_next  = 2'd3;
          sequence_length_next  = 2'd3;
        end
      end
    end

    if (item.end_of_text) begin
      if (bytes_remaining_next != 2'd0) begin
        error_seen_next = 1'b1;
        if (cnt != 2'd3) begin
          units[cnt] = utt_pkg::plain_unit(utt_pkg::REPLACEMENT_CHAR, error_seen_next);
          cnt = cnt + 2'd1;
        end
      end
      if (cnt != 2'd3) begin
        units[cnt] = '{code_unit: '0, unit_valid: nul_terminate, text_done: 1'b1,
                       had_errors: error_seen_next};
        cnt = cnt + 2'd1;
      end
      // start the next text fresh
      bytes_remaining_next  = 2'd0;
      sequence_length_next  = 2'd0;
      code_accumulator_next = '0;
      skipping_next         = 1'b0;
      prev_high_next        = 1'b0;
      error_seen_next       = 1'b0;
    end

    bundle.units = units;
    bundle.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining  <= 2'd0;
      sequence_length  <= 2'd0;
      code_accumulator <= '0;
      skipping         <= 1'b0;
      prev_high        <= 1'b0;
      error_seen       <= 1'b0;
    end else if (advance) begin
      bytes_remaining  <= bytes_remaining_next;
      sequence_length  <= sequence_length_next;
      code_accumulator <= code_accumulator_next;
      skipping         <= skipping_next;
      prev_high        <= prev_high_next;
      error_seen       <= error_seen_next;
    end
  end

endmodule

FILE: sv/utt_result_buf.sv
// Result register: holds the results of one item and hands them out one transfer at a time.
// Depends on utt_pkg and utt_out_if.
module utt_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  utt_pkg::bundle_t bundle_in,
  output logic             can_load,
  utt_out_if.source        out_ch
);

  utt_pkg::bundle_t bundle;
  logic             held;
  logic [1:0]       idx;
  logic             last;
  utt_pkg::unit_t   cur;

  always_comb begin
    case (idx)
      2'd0:    cur = bundle.units[0];
      2'd1:    cur = bundle.units[1];
      2'd2:    cur = bundle.units[2];
      default: cur = '0;
    endcase
  end

  assign last     = (idx == bundle.count - 2'd1);
  assign can_load = !held || (out_ch.ready && last);

  assign out_ch.valid        = held;
  assign out_ch.code_unit    = cur.code_unit;
  assign out_ch.unit_valid   = cur.unit_valid;
  assign out_ch.last_of_item = last;
  assign out_ch.text_done    = cur.text_done;
  assign out_ch.had_errors   = cur.had_errors;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= 2'd0;
    end else if (held && out_ch.ready) begin
      if (last) begin
        held <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_in;
    end
  end

endmodule

FILE: sv/utf8_to_utf16_utf32_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16/UTF-32 transcoder: input register, config, decode, output.
// Depends on utt_pkg, utt_in_if, utt_out_if, utt_decode and utt_result_buf.
//
//   channel   dir  transfer carries                                      per item
//   byte_in   in   data_byte, has_byte, end_of_text                      one
//   unit_out  out  code_unit, unit_valid, last_of_item, text_done,       zero to three
//                  had_errors
//   cfg       in   cfg_we, cfg_index, cfg_data (write only, no wait)     -
//
// An item is captured in the input register and decoded there, and its results are then loaded
// into the result register, from which the first result can transfer. Items that yield no result
// flow at one per cycle, and items with one result do so while unit_out is ready; an item with
// several results holds the result register until its last result transfers, at one unit_out
// transfer per cycle while the receiver is ready.
// Reset is synchronous and clears the decoder state, the config and both valid flags.
// A stall on unit_out holds the result register; byte_in keeps taking an item while the
// input register is free or its item advances in the same cycle.
module utf8_to_utf16_utf32_transcoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data,
  utt_in_if.sink     byte_in,
  utt_out_if.source  unit_out
);

  logic             output_utf32;
  logic             nul_terminate;

  utt_pkg::item_t   item;
  logic             item_held;
  utt_pkg::bundle_t bundle;
  logic             can_load;
  logic             advance;
  logic             load;

  // Config writes: to be made only while the block is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      output_utf32  <= 1'b0;
      nul_terminate <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        utt_pkg::CFG_OUTPUT_UTF32:  output_utf32  <= cfg_data;
        utt_pkg::CFG_NUL_TERMINATE: nul_terminate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held item when its results fit in the result register; an item that
  // yields nothing only updates the decoder state and never waits.
  assign advance       = item_held && (bundle.count == 2'd0 || can_load);
  assign load          = advance && (bundle.count != 2'd0);
  assign byte_in.ready = !item_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (byte_in.ready) begin
      item_held <= byte_in.valid;
    end
  end

  // Payload of the input register: capture on every transfer
  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      item.data_byte   <= byte_in.data_byte;
      item.has_byte    <= byte_in.has_byte;
      item.end_of_text <= byte_in.end_of_text;
    end
  end

  utt_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (item),
    .output_utf32  (output_utf32),
    .nul_terminate (nul_terminate),
    .bundle        (bundle)
  );

  utt_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bundle_in (bundle),
    .can_load  (can_load),
    .out_ch    (unit_out)
  );

endmodule

FILE: sv/utt_checker.sv
// Port-level checks of the transcoder, attached to the top level by bind.
// Depends on utt_pkg and the top level utf8_to_utf16_utf32_transcoder_unit.
module utt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [utt_pkg::CodeW-1:0] code_unit,
  input logic                      unit_valid,
  input logic                      last_of_item,
  input logic                      text_done
);

  // A stalled result holds its unit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit))
    else $error("stalled result changed");

  // The closing result ends its item and carries a zero unit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> last_of_item && code_unit == '0)
    else $error("closing result malformed");

  // Only a closing result may be marked as not a unit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> text_done)
    else $error("invalid unit outside closing result");

  // No unit beyond the code space
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> code_unit < utt_pkg::CODE_LIMIT)
    else $error("unit out of range");

endmodule

bind utf8_to_utf16_utf32_transcoder_unit utt_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (unit_out.valid),
  .out_ready    (unit_out.ready),
  .code_unit    (unit_out.code_unit),
  .unit_valid   (unit_out.unit_valid),
  .last_of_item (unit_out.last_of_item),
  .text_done    (unit_out.text_done)
);

FILE: sim/tb_top.sv
// Self-checking testbench of utf8_to_utf16_utf32_transcoder_unit.
// It feeds UTF-8 texts through byte_in, decodes them again on its own side and checks unit_out.
// Depends on utt_pkg, utt_in_if, utt_out_if and the transcoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeW = utt_pkg::CodeW;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  // Extra wait after the drain, so that items that yield no result can pass the input register.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 150;

  localparam logic [CodeW-1:0] HIGH_UNIT       = 21'h00D800;
  localparam logic [CodeW-1:0] LOW_UNIT        = 21'h00DC00;
  localparam logic [CodeW-1:0] TEN_BITS        = 21'h0003FF;
  localparam logic [CodeW-1:0] SURR_HALF_MASK  = 21'h00FC00;
  localparam logic [CodeW-1:0] SURR_BLOCK_MASK = 21'h00F800;

  typedef struct packed {
    logic [CodeW-1:0] code_unit;
    logic             unit_valid;
    logic             last_of_item;
    logic             text_done;
    logic             had_errors;
  } unit_rec_t;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  utt_in_if  byte_in_ch ();
  utt_out_if unit_out_ch ();

  utf8_to_utf16_utf32_transcoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .byte_in  (byte_in_ch),
    .unit_out (unit_out_ch)
  );

  // Our copy of the registers and of the decoder state
  logic             want_utf32;
  logic             want_nul;
  logic [1:0]       cont_left;
  logic [1:0]       seq_len;
  logic [CodeW-1:0] code_acc;
  logic             skip_cont;
  logic             prev_high;
  logic             err_seen;

  unit_rec_t   item_units[$];
  unit_rec_t   expected_units[$];

  int unsigned errors;
  int unsigned counted_items;
  int unsigned items_accepted;
  int unsigned units_checked;
  int unsigned texts_closed;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned hold_request;

  // ---------------------------------------------------------------------------------------
  // Clock and cycle watchdog
  // ---------------------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("utf8_to_utf16_utf32_transcoder_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Decoder prediction: one call per accepted item, results land in item_units
  // ---------------------------------------------------------------------------------------
  function automatic void put_unit(logic [CodeW-1:0] cu, logic valid, logic done);
    unit_rec_t r;
    // The block carries at most MaxUnits results per item; drop anything past that.
    if (item_units.size() >= utt_pkg::MaxUnits) return;
    r.code_unit    = cu;
    r.unit_valid   = valid;
    r.last_of_item = 1'b0;
    r.text_done    = done;
    r.had_errors   = err_seen;
    item_units.push_back(r);
  endfunction

  function automatic void emit_unit(logic [CodeW-1:0] u);
    put_unit(u, 1'b1, 1'b0);
    // Only the low 16 bits decide, so a UTF-32 point like U+1D800 counts as well.
    prev_high = ((u & SURR_HALF_MASK) == HIGH_UNIT);
  endfunction

  function automatic void emit_code_point(logic [CodeW-1:0] u);
    logic [CodeW-1:0] offs;
    if (!want_utf32 && u >= utt_pkg::SUPP_BASE) begin
      offs = u - utt_pkg::SUPP_BASE;
      emit_unit(HIGH_UNIT | (offs >> 10));
      emit_unit(LOW_UNIT | (offs & TEN_BITS));
    end else begin
      emit_unit(u);
    end
  endfunction

  function automatic void reject();
    err_seen = 1'b1;
    emit_unit(utt_pkg::REPLACEMENT_CHAR);
    skip_cont = 1'b1;
  endfunction

  function automatic void begin_sequence(logic [7:0] b);
    if (b < 8'h80) begin
      emit_unit(CodeW'(b));
    end else if (b < 8'hC0) begin
      reject();
    end else if (b < 8'hE0) begin
      code_acc = CodeW'(b[4:0]);
      cont_left = 2'd1;
      seq_len = 2'd1;
    end else if (b < 8'hF0) begin
      code_acc = CodeW'(b[3:0]);
      cont_left = 2'd2;
      seq_len = 2'd2;
    end else if (b < 8'hF8) begin
      code_acc = CodeW'(b[2:0]);
      cont_left = 2'd3;
      seq_len = 2'd3;
    end else begin
      reject();
    end
  endfunction

  function automatic void complete_sequence();
    logic [CodeW-1:0] u;
    logic [1:0]       len;
    u = code_acc;
    len = seq_len;
    seq_len = 2'd0;
    code_acc = '0;
    if (len == 2'd1) begin
      if (u < utt_pkg::TWO_BYTE_MIN) reject();
      else emit_unit(u);
    end else if (len == 2'd2) begin
      if (u < utt_pkg::THREE_BYTE_MIN) begin
        reject();
      end else if ((u & SURR_BLOCK_MASK) == HIGH_UNIT) begin
        // Encoded surrogate: passed on but flagged, unless it is a low half right after a high.
        if ((u & SURR_HALF_MASK) == LOW_UNIT && prev_high) begin
          reject();
        end else begin
          err_seen = 1'b1;
          emit_unit(u);
        end
      end else begin
        emit_unit(u);
      end
    end else begin
      if (u < utt_pkg::SUPP_BASE || u >= utt_pkg::CODE_LIMIT) reject();
      else emit_code_point(u);
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic is_cont;
    is_cont = (b[7:6] == 2'b10);
    if (cont_left != 2'd0) begin
      if (!is_cont) begin
        // Sequence cut short: replace it, then treat this byte as a fresh lead
        cont_left = 2'd0;
        seq_len = 2'd0;
        code_acc = '0;
        reject();
        skip_cont = 1'b0;
        begin_sequence(b);
      end else begin
        code_acc = (code_acc << 6) | CodeW'(b[5:0]);
        cont_left--;
        if (cont_left == 2'd0) complete_sequence();
      end
    end else if (!(skip_cont && is_cont)) begin
      skip_cont = 1'b0;
      begin_sequence(b);
    end
  endfunction

  function automatic void clear_text_state();
    cont_left = 2'd0;
    seq_len = 2'd0;
    code_acc = '0;
    skip_cont = 1'b0;
    prev_high = 1'b0;
    err_seen = 1'b0;
  endfunction

  function automatic void decode_utf8_item(logic [7:0] b, logic has, logic eot);
    item_units.delete();
    if (has) take_byte(b);
    if (eot) begin
      if (cont_left != 2'd0) begin
        cont_left = 2'd0;
        seq_len = 2'd0;
        code_acc = '0;
        reject();
      end
      put_unit('0, want_nul, 1'b1);
      clear_text_state();
    end
    if (item_units.size() > 0) item_units[item_units.size() - 1].last_of_item = 1'b1;
    foreach (item_units[i]) expected_units.push_back(item_units[i]);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Monitors: predict on every byte_in transfer, check every unit_out transfer
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && byte_in_ch.valid && byte_in_ch.ready) begin
      items_accepted++;
      decode_utf8_item(byte_in_ch.data_byte, byte_in_ch.has_byte, byte_in_ch.end_of_text);
    end
  end

  task automatic check_field(input string what, input logic [CodeW-1:0] want,
                             input logic [CodeW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_units
    unit_rec_t want;
    if (!rst && unit_out_ch.valid && unit_out_ch.ready) begin
      units_checked++;
      if (unit_out_ch.text_done === 1'b1) texts_closed++;
      if (expected_units.size() == 0) begin
        $display("%0t ns: unexpected unit, expected none, got code_unit 0x%0h", $time,
                 unit_out_ch.code_unit);
        errors++;
      end else begin
        want = expected_units.pop_front();
        check_field("code_unit", want.code_unit, unit_out_ch.code_unit);
        check_field("unit_valid", CodeW'(want.unit_valid), CodeW'(unit_out_ch.unit_valid));
        check_field("last_of_item", CodeW'(want.last_of_item),
                    CodeW'(unit_out_ch.last_of_item));
        check_field("text_done", CodeW'(want.text_done), CodeW'(unit_out_ch.text_done));
        check_field("had_errors", CodeW'(want.had_errors), CodeW'(unit_out_ch.had_errors));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: switch between stall patterns; honor a long hold-off when one is requested
  // ---------------------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    unit_out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      if (hold_left != 0) begin
        // Hold off the output while the sender keeps pushing bytes
        hold_left--;
        unit_out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STREAM:  unit_out_ch.ready <= 1'b1;
          RX_COIN:    unit_out_ch.ready <= 1'($urandom_range(0, 1));
          RX_CADENCE: unit_out_ch.ready <= (mode_left % 4 != 0);
          default:    unit_out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender side: one transfer per call, bursts of random length with random gaps
  // ---------------------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic has, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        @(negedge clk);
        byte_in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    byte_in_ch.valid       <= 1'b1;
    byte_in_ch.data_byte   <= b;
    byte_in_ch.has_byte    <= has;
    byte_in_ch.end_of_text <= eot;
    do @(posedge clk); while (!byte_in_ch.ready);
    // Pure no-op items don't count toward the stimulus size
    if (has || eot) counted_items++;
  endtask

  // Encode cp in a len-byte form (overlong or out of range if asked) and send the first keep bytes
  task automatic send_sequence(input logic [CodeW-1:0] cp, input int unsigned len,
                               input int unsigned keep, input logic eot);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < int'(keep); i++) send_item(seq[i], 1'b1, eot && (i == int'(keep) - 1));
  endtask

  // Drop valid, drain every expected unit, then let in-flight no-result items pass
  task automatic settle();
    @(negedge clk);
    byte_in_ch.valid <= 1'b0;
    while (expected_units.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == utt_pkg::CFG_OUTPUT_UTF32) want_utf32 = val;
    else want_nul = val;
  endtask

  // Mostly well-formed characters with random content, the rest malformed or markers
  task automatic run_random_text(input int unsigned n_items);
    int unsigned      stop_at;
    int unsigned      pick;
    int unsigned      len;
    logic [CodeW-1:0] cp;
    logic             eot;
    stop_at = counted_items + n_items;
    while (counted_items < stop_at) begin
      pick = $urandom_range(0, 99);
      eot = ($urandom_range(0, 11) == 0);
      if (pick < 15) begin
        send_sequence(CodeW'($urandom_range(0, 'h7F)), 1, 1, eot);
      end else if (pick < 30) begin
        send_sequence(CodeW'($urandom_range('h80, 'h7FF)), 2, 2, eot);
      end else if (pick < 45) begin
        send_sequence(CodeW'($urandom_range('h800, 'hFFFF)), 3, 3, eot);
      end else if (pick < 53) begin
        // Encoded surrogate halves, so high/low pairs show up now and then
        send_sequence(CodeW'($urandom_range('hD800, 'hDFFF)), 3, 3, eot);
      end else if (pick < 68) begin
        send_sequence(CodeW'($urandom_range('h10000, 'h10FFFF)), 4, 4, eot);
      end else if (pick < 74) begin
        // Overlong: a value that fits a shorter form
        len = $urandom_range(2, 4);
        case (len)
          2: cp = CodeW'($urandom_range(0, 'h7F));
          3: cp = CodeW'($urandom_range(0, 'h7FF));
          default: cp = CodeW'($urandom_range(0, 'hFFFF));
        endcase
        send_sequence(cp, len, len, eot);
      end else if (pick < 78) begin
        send_sequence(CodeW'($urandom_range('h110000, 'h1FFFFF)), 4, 4, eot);
      end else if (pick < 86) begin
        // Truncated: the next lead byte or the end of text cuts it short
        len = $urandom_range(2, 4);
        send_sequence(CodeW'($urandom_range('h80, 'h1FFFFF)), len,
                      $urandom_range(1, len - 1), eot);
      end else if (pick < 93) begin
        send_item(8'($urandom_range(0, 255)), 1'b1, eot);
      end else if (pick < 97) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // One text of edge forms, then an empty text, at reset settings (UTF-16, no NUL)
  task automatic test_directed_forms();
    logic [7:0] text [$];
    text = '{8'h00, 8'h7F,                 // ASCII extremes
             8'hC2, 8'h80,                 // smallest two-byte form
             8'h80, 8'hBF,                 // stray continuation, then one that gets dropped
             8'hC1, 8'hBF,                 // overlong two-byte form
             8'hED, 8'hA0, 8'h80,          // high surrogate, passed and flagged
             8'hED, 8'hB0, 8'h80,          // low surrogate right after it: replaced
             8'hF4, 8'h8F, 8'hBF, 8'hBF,   // U+10FFFF as a surrogate pair
             8'hF4, 8'h90, 8'h80, 8'h80,   // above U+10FFFF
             8'hFF,                        // byte never valid in UTF-8
             8'hE2, 8'h41,                 // sequence cut short by an ASCII byte
             8'hF0, 8'h9F};                // text ends mid-sequence
    foreach (text[i]) send_item(text[i], 1'b1, i == text.size() - 1);
    send_item(8'hA5, 1'b0, 1'b0);  // no byte, no end: nothing happens
    send_item(8'h5A, 1'b0, 1'b1);  // bare end marker on an empty text
    settle();
  endtask

  // Random texts under every register combination, extremes included
  task automatic test_config_sweep();
    logic [1:0] combo;
    for (int k = 0; k < 4; k++) begin
      combo = {k[0] ^ k[1], k[0]};
      write_reg(utt_pkg::CFG_OUTPUT_UTF32, combo[1]);
      write_reg(utt_pkg::CFG_NUL_TERMINATE, combo[0]);
      run_random_text(15);
      settle();
    end
  endtask

  // Switch the registers inside a text; the surrogate memory must survive the switch
  task automatic test_mid_text_switch();
    write_reg(utt_pkg::CFG_OUTPUT_UTF32, 1'b0);
    write_reg(utt_pkg::CFG_NUL_TERMINATE, 1'b0);
    send_sequence(HIGH_UNIT, 3, 3, 1'b0);
    settle();
    write_reg(utt_pkg::CFG_OUTPUT_UTF32, 1'b1);
    send_sequence(LOW_UNIT, 3, 3, 1'b0);
    // U+1D800 in UTF-32 looks like a high half in its low 16 bits
    send_sequence(21'h01D800, 4, 4, 1'b0);
    settle();
    write_reg(utt_pkg::CFG_NUL_TERMINATE, 1'b1);
    send_sequence(LOW_UNIT, 3, 3, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  // Hold the output for a long stretch while four-byte characters keep coming
  task automatic test_output_backpressure();
    write_reg(utt_pkg::CFG_OUTPUT_UTF32, 1'b0);
    hold_request = LONG_HOLD;
    repeat (12) send_sequence(CodeW'($urandom_range('h10000, 'h10FFFF)), 4, 4, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin : run
    errors = 0;
    counted_items = 0;
    items_accepted = 0;
    units_checked = 0;
    texts_closed = 0;
    burst_left = 0;
    hold_request = 0;
    want_utf32 = 1'b0;
    want_nul = 1'b0;
    clear_text_state();

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    byte_in_ch.valid = 1'b0;
    byte_in_ch.data_byte = 8'h00;
    byte_in_ch.has_byte = 1'b0;
    byte_in_ch.end_of_text = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed_forms();
    test_config_sweep();
    test_mid_text_switch();
    test_output_backpressure();

    // Any stray unit after the drain shows up as unexpected
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d byte_in transfers and %0d unit_out transfers over %0d texts,",
             items_accepted, units_checked, texts_closed);
    $display("all four register settings, mid-text register changes and a long output stall.");
    if (errors == 0 && expected_units.size() == 0) begin
      $display("utf8_to_utf16_utf32_transcoder_unit verification clean");
    end else begin
      $display("utf8_to_utf16_utf32_transcoder_unit verification failed");
    end
    $finish;
  end

endmodule
